// File: src/tcw_pkg.sv
// shared types, constants and address helper for the text console writer
// no dependencies; imported by every module of the block
package tcw_pkg;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELL_COUNT  = COLUMNS * ROWS;
   localparam int SHIFT_COUNT = (ROWS - 1) * COLUMNS;
   localparam int ADDR_W      = $clog2(CELL_COUNT);
   localparam int CNT_W       = $clog2(CELL_COUNT + 1);
   localparam int ROW_W       = 5;
   localparam int COL_W       = 7;

   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] DEFAULT_ATTR = 8'h07;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] RETURN_CHAR  = 8'h0D;

   localparam logic [ADDR_W-1:0] LAST_ROW_ADDR = ADDR_W'(SHIFT_COUNT);

   typedef enum logic [1:0] {
      KIND_PRINT = 2'd0,
      KIND_SET   = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       char_code;
      logic [7:0]       attr_byte;
      logic [ROW_W-1:0] target_row;
      logic [COL_W-1:0] target_col;
   } req_type;

   typedef struct packed {
      logic [15:0]      cell_value;
      logic [ROW_W-1:0] cur_row;
      logic [COL_W-1:0] cur_col;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [15:0]       wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   // linear cell address, row must be below ROWS
   function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                    logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

// File: src/tcw_ram.sv
// screen cell store: one write port, one read port, registered read data
// depends on tcw_pkg
module tcw_ram
   import tcw_pkg::*;
(
   input  logic        clock,
   input  ram_req_type ram_req,
   output logic [15:0] rd_data
);

   logic [15:0] cells_ff [CELL_COUNT];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         cells_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= cells_ff[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/tcw_ctrl.sv
// command sequencer: cursor, fill/scroll sweeps and result register
// depends on tcw_pkg; drives the tcw_ram ports
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_strobe,
   output rsp_type     rsp_item,
   output ram_req_type ram_req,
   input  logic [15:0] rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_READ,
      ST_SC_ATTR,
      ST_SC_COPY,
      ST_SC_FILL,
      ST_SC_CHAR
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [15:0]      fill_val_ff, fill_val_in;
   logic [15:0]      char_val_ff, char_val_in;
   logic             rsp_pend_ff, rsp_pend_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;
   logic [15:0]      cell_in;
   logic [ROW_W-1:0] wrap_row;
   logic [COL_W-1:0] wrap_col;
   logic [7:0]       old_attr;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      fill_val_in   = fill_val_ff;
      char_val_in   = char_val_ff;
      rsp_pend_in   = rsp_pend_ff;
      rsp_strobe_in = 1'b0;
      cell_in       = '0;
      ram_req       = '0;
      old_attr      = rd_data[15:8];

      // wrap at end of row before an ordinary character
      if (col_ff >= COL_W'(COLUMNS)) begin
         wrap_col = '0;
         wrap_row = (row_ff < ROW_W'(ROWS)) ? row_ff + ROW_W'(1) : row_ff;
      end else begin
         wrap_col = col_ff;
         wrap_row = row_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_item.kind)
                  KIND_PRINT: begin
                     if (req_item.char_code == NEWLINE_CHAR) begin
                        col_in        = '0;
                        row_in        = (row_ff < ROW_W'(ROWS)) ? row_ff + ROW_W'(1) : row_ff;
                        rsp_strobe_in = 1'b1;
                     end else if (req_item.char_code == RETURN_CHAR) begin
                        col_in        = '0;
                        rsp_strobe_in = 1'b1;
                     end else if (wrap_row >= ROW_W'(ROWS)) begin
                        // scroll first: fetch the fill attribute from the last row
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = LAST_ROW_ADDR;
                        char_val_in     = {req_item.attr_byte, req_item.char_code};
                        state_in        = ST_SC_ATTR;
                     end else begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = cell_addr(wrap_row, wrap_col);
                        ram_req.wr_data = {req_item.attr_byte, req_item.char_code};
                        row_in          = wrap_row;
                        col_in          = wrap_col + COL_W'(1);
                        rsp_strobe_in   = 1'b1;
                     end
                  end
                  KIND_SET: begin
                     row_in = (req_item.target_row > ROW_W'(ROWS)) ?
                              ROW_W'(ROWS) : req_item.target_row;
                     col_in = (req_item.target_col > COL_W'(COLUMNS)) ?
                              COL_W'(COLUMNS) : req_item.target_col;
                     rsp_strobe_in = 1'b1;
                  end
                  KIND_CLEAR: begin
                     fill_val_in = {req_item.attr_byte, BLANK_CHAR};
                     cnt_in      = '0;
                     rsp_pend_in = 1'b1;
                     row_in      = '0;
                     col_in      = '0;
                     state_in    = ST_FILL;
                  end
                  default: begin
                     if (req_item.target_row < ROW_W'(ROWS) &&
                         req_item.target_col < COL_W'(COLUMNS)) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = cell_addr(req_item.target_row,
                                                    req_item.target_col);
                        state_in        = ST_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_FILL: begin
            // whole-screen sweep, used for clear and for the reset pass
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = cnt_ff[ADDR_W-1:0];
            ram_req.wr_data = fill_val_ff;
            cnt_in          = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = rsp_pend_ff;
               rsp_pend_in   = 1'b0;
            end
         end
         ST_READ: begin
            cell_in       = rd_data;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SC_ATTR: begin
            fill_val_in = {(old_attr == 8'h00) ? DEFAULT_ATTR : old_attr, BLANK_CHAR};
            cnt_in      = '0;
            state_in    = ST_SC_COPY;
         end
         ST_SC_COPY: begin
            // read one row ahead, write back the previous read in the next cycle
            if (cnt_ff < CNT_W'(SHIFT_COUNT)) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = cnt_ff[ADDR_W-1:0] + ADDR_W'(COLUMNS);
            end
            if (cnt_ff != '0) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = cnt_ff[ADDR_W-1:0] - ADDR_W'(1);
               ram_req.wr_data = rd_data;
            end
            if (cnt_ff == CNT_W'(SHIFT_COUNT)) begin
               cnt_in   = '0;
               state_in = ST_SC_FILL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SC_FILL: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = LAST_ROW_ADDR + cnt_ff[ADDR_W-1:0];
            ram_req.wr_data = fill_val_ff;
            cnt_in          = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(COLUMNS - 1)) begin
               state_in = ST_SC_CHAR;
            end
         end
         ST_SC_CHAR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = LAST_ROW_ADDR;
            ram_req.wr_data = char_val_ff;
            row_in          = ROW_W'(ROWS - 1);
            col_in          = COL_W'(1);
            rsp_strobe_in   = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.cell_value = cell_in;
      rsp_in.cur_row    = row_in;
      rsp_in.cur_col    = col_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         cnt_ff        <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         fill_val_ff   <= '0;
         rsp_pend_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         fill_val_ff   <= fill_val_in;
         rsp_pend_ff   <= rsp_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      char_val_ff <= char_val_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// File: src/text_console_writer_core.sv
// text console writer top level: sequencer plus screen cell store
// depends on tcw_pkg, tcw_ctrl and tcw_ram
//
// print without scroll, newline, return, set cursor and an out-of-range
//   read give the result in the cycle after acceptance; an in-range
//   read first waits in ST_READ for the registered memory read data
// a clear sweeps all ROWS*COLUMNS cells one per cycle, then registers the
//   result; a print that scrolls fetches the fill attribute, copies
//   (ROWS-1)*COLUMNS cells up one row, fills the last row, writes the
//   character and registers the result, bound by the single memory write port
// print without scroll, newline, return, set cursor and an out-of-range
//   read never raise busy, so one item per cycle is taken for them; an
//   in-range read holds busy for one cycle; the receiver cannot stall
// reset (synchronous) zeroes the cursor and starts a clearing pass that
//   writes zero to every cell; busy stays high throughout
module text_console_writer_core
   import tcw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   // memory request bundle from the sequencer
   ram_req_type ram_req;
   logic [15:0] rd_data;

   // command decode, cursor and sweep counters
   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .ram_req    (ram_req),
      .rd_data    (rd_data)
   );

   // attribute/character cells, row-major
   tcw_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

// File: src/tcw_checker.sv
// port-level checks for the text console writer, bound to the top level
// depends on tcw_pkg and text_console_writer_core
module tcw_checker
   import tcw_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // reset always starts the clearing pass
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.cur_row <= ROW_W'(ROWS)) &&
                     (rsp_item.cur_col <= COL_W'(COLUMNS)))
      else $error("cursor out of range");

   // a clear sweeps the screen, so no result in the next cycle
   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.kind == KIND_CLEAR) |=> busy && !rsp_strobe)
      else $error("clear did not start a sweep");

   a_set_cursor: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.kind == KIND_SET &&
       req_item.target_row <= ROW_W'(ROWS) && req_item.target_col <= COL_W'(COLUMNS))
      |=> rsp_strobe && rsp_item.cell_value == 16'h0000 &&
          rsp_item.cur_row == $past(req_item.target_row) &&
          rsp_item.cur_col == $past(req_item.target_col))
      else $error("set cursor result wrong");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
